FILE: src/qc_pkg.sv
// Package for the quadrilateral classifier: class codes, point indexes, ordering logic.
`default_nettype none
package qc_pkg;

    // Register stages from input acceptance to the output register
    localparam int NUM_STAGES = 7;

    typedef enum logic [2:0] {
        SHAPE_SQUARE    = 3'd0,
        SHAPE_RECTANGLE = 3'd1,
        SHAPE_RHOMBUS   = 3'd2,
        SHAPE_OTHER     = 3'd3,
        SHAPE_NOLABEL   = 3'd4
    } shape_class_t;

    // Index of one of the three movable points (B, C, D)
    typedef logic [1:0] pt_idx_t;
    localparam pt_idx_t PT_B = 2'd0;
    localparam pt_idx_t PT_C = 2'd1;
    localparam pt_idx_t PT_D = 2'd2;

    // Sign of one pairwise cross product
    typedef struct packed {
        logic neg;
        logic pos;
    } cross_sign_t;

    typedef struct packed {
        pt_idx_t p2;
        pt_idx_t p3;
        pt_idx_t p4;
    } pt_order_t;

    // True when cross(Pi - A, Pj - A) < 0, from the signs of the canonical pairs
    function automatic logic cross_neg(pt_idx_t i, pt_idx_t j,
                                       cross_sign_t bc, cross_sign_t bd,
                                       cross_sign_t cd);
        logic r;
        case ({i, j})
            {PT_B, PT_C}: r = bc.neg;
            {PT_C, PT_B}: r = bc.pos;
            {PT_B, PT_D}: r = bd.neg;
            {PT_D, PT_B}: r = bd.pos;
            {PT_C, PT_D}: r = cd.neg;
            {PT_D, PT_C}: r = cd.pos;
            default:      r = 1'b0;
        endcase
        return r;
    endfunction

    // Three compare-and-swaps that put B, C, D into angular order around A
    function automatic pt_order_t sort_points(cross_sign_t bc, cross_sign_t bd,
                                              cross_sign_t cd);
        pt_order_t o;
        pt_idx_t   t;
        o.p2 = PT_B;
        o.p3 = PT_C;
        o.p4 = PT_D;
        if (cross_neg(o.p2, o.p3, bc, bd, cd)) begin
            t = o.p2; o.p2 = o.p3; o.p3 = t;
        end
        if (cross_neg(o.p2, o.p4, bc, bd, cd)) begin
            t = o.p2; o.p2 = o.p4; o.p4 = t;
        end
        if (cross_neg(o.p3, o.p4, bc, bd, cd)) begin
            t = o.p3; o.p3 = o.p4; o.p4 = t;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: src/qc_cross.sv
// Stages 0 to 2: offsets from point A and signs of the three pairwise cross products.
`default_nettype none
module qc_cross #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic [2:0]                    adv,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [COORD_WIDTH-1:0] cx,
    input  wire logic signed [COORD_WIDTH-1:0] cy,
    input  wire logic signed [COORD_WIDTH-1:0] dx,
    input  wire logic signed [COORD_WIDTH-1:0] dy,
    output logic signed [COORD_WIDTH:0]        vbx,
    output logic signed [COORD_WIDTH:0]        vby,
    output logic signed [COORD_WIDTH:0]        vcx,
    output logic signed [COORD_WIDTH:0]        vcy,
    output logic signed [COORD_WIDTH:0]        vdx,
    output logic signed [COORD_WIDTH:0]        vdy,
    output qc_pkg::cross_sign_t                sgn_bc,
    output qc_pkg::cross_sign_t                sgn_bd,
    output qc_pkg::cross_sign_t                sgn_cd
);
    import qc_pkg::*;

    localparam int V  = COORD_WIDTH + 1;
    localparam int PW = 2 * V;

    // Stage 0: offsets of B, C, D from A
    logic signed [V-1:0] s0_bx_reg, s0_by_reg, s0_cx_reg, s0_cy_reg, s0_dx_reg, s0_dy_reg;
    // Stage 1: offsets carried, cross product terms
    logic signed [V-1:0] s1_bx_reg, s1_by_reg, s1_cx_reg, s1_cy_reg, s1_dx_reg, s1_dy_reg;
    logic signed [PW-1:0] bc_l_reg, bc_r_reg, bd_l_reg, bd_r_reg, cd_l_reg, cd_r_reg;
    // Stage 2: offsets carried, cross signs
    logic signed [V-1:0] s2_bx_reg, s2_by_reg, s2_cx_reg, s2_cy_reg, s2_dx_reg, s2_dy_reg;
    cross_sign_t sgn_bc_reg, sgn_bd_reg, sgn_cd_reg;

    logic signed [PW:0] bc_diff, bd_diff, cd_diff;

    assign bc_diff = (PW+1)'(bc_l_reg) - (PW+1)'(bc_r_reg);
    assign bd_diff = (PW+1)'(bd_l_reg) - (PW+1)'(bd_r_reg);
    assign cd_diff = (PW+1)'(cd_l_reg) - (PW+1)'(cd_r_reg);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s0_bx_reg <= V'(bx) - V'(ax);
            s0_by_reg <= V'(by) - V'(ay);
            s0_cx_reg <= V'(cx) - V'(ax);
            s0_cy_reg <= V'(cy) - V'(ay);
            s0_dx_reg <= V'(dx) - V'(ax);
            s0_dy_reg <= V'(dy) - V'(ay);
        end
        if (adv[1]) begin
            s1_bx_reg <= s0_bx_reg;
            s1_by_reg <= s0_by_reg;
            s1_cx_reg <= s0_cx_reg;
            s1_cy_reg <= s0_cy_reg;
            s1_dx_reg <= s0_dx_reg;
            s1_dy_reg <= s0_dy_reg;
            bc_l_reg  <= s0_bx_reg * s0_cy_reg;
            bc_r_reg  <= s0_cx_reg * s0_by_reg;
            bd_l_reg  <= s0_bx_reg * s0_dy_reg;
            bd_r_reg  <= s0_dx_reg * s0_by_reg;
            cd_l_reg  <= s0_cx_reg * s0_dy_reg;
            cd_r_reg  <= s0_dx_reg * s0_cy_reg;
        end
        if (adv[2]) begin
            s2_bx_reg      <= s1_bx_reg;
            s2_by_reg      <= s1_by_reg;
            s2_cx_reg      <= s1_cx_reg;
            s2_cy_reg      <= s1_cy_reg;
            s2_dx_reg      <= s1_dx_reg;
            s2_dy_reg      <= s1_dy_reg;
            sgn_bc_reg.neg <= bc_diff < 0;
            sgn_bc_reg.pos <= bc_diff > 0;
            sgn_bd_reg.neg <= bd_diff < 0;
            sgn_bd_reg.pos <= bd_diff > 0;
            sgn_cd_reg.neg <= cd_diff < 0;
            sgn_cd_reg.pos <= cd_diff > 0;
        end
    end

    assign vbx    = s2_bx_reg;
    assign vby    = s2_by_reg;
    assign vcx    = s2_cx_reg;
    assign vcy    = s2_cy_reg;
    assign vdx    = s2_dx_reg;
    assign vdy    = s2_dy_reg;
    assign sgn_bc = sgn_bc_reg;
    assign sgn_bd = sgn_bd_reg;
    assign sgn_cd = sgn_cd_reg;

endmodule
`default_nettype wire

FILE: src/qc_order.sv
// Stage 3: angular ordering of the points and the edge vectors of the polygon.
`default_nettype none
module qc_order #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        adv,
    input  wire logic signed [COORD_WIDTH:0] vbx,
    input  wire logic signed [COORD_WIDTH:0] vby,
    input  wire logic signed [COORD_WIDTH:0] vcx,
    input  wire logic signed [COORD_WIDTH:0] vcy,
    input  wire logic signed [COORD_WIDTH:0] vdx,
    input  wire logic signed [COORD_WIDTH:0] vdy,
    input  wire qc_pkg::cross_sign_t         sgn_bc,
    input  wire qc_pkg::cross_sign_t         sgn_bd,
    input  wire qc_pkg::cross_sign_t         sgn_cd,
    output logic signed [COORD_WIDTH:0]      v2x,
    output logic signed [COORD_WIDTH:0]      v2y,
    output logic signed [COORD_WIDTH:0]      v4x,
    output logic signed [COORD_WIDTH:0]      v4y,
    output logic signed [COORD_WIDTH+1:0]    ux,
    output logic signed [COORD_WIDTH+1:0]    uy,
    output logic signed [COORD_WIDTH+1:0]    wx,
    output logic signed [COORD_WIDTH+1:0]    wy
);
    import qc_pkg::*;

    localparam int V = COORD_WIDTH + 1;
    localparam int U = COORD_WIDTH + 2;

    function automatic logic signed [V-1:0] pick(pt_idx_t i, logic signed [V-1:0] b,
                                                 logic signed [V-1:0] c,
                                                 logic signed [V-1:0] d);
        logic signed [V-1:0] r;
        case (i)
            PT_B:    r = b;
            PT_C:    r = c;
            default: r = d;
        endcase
        return r;
    endfunction

    pt_order_t ord;
    logic signed [V-1:0] p2x, p2y, p3x, p3y, p4x, p4y;
    logic signed [V-1:0] v2x_reg, v2y_reg, v4x_reg, v4y_reg;
    logic signed [U-1:0] ux_reg, uy_reg, wx_reg, wy_reg;

    always_comb begin
        ord = sort_points(sgn_bc, sgn_bd, sgn_cd);
        p2x = pick(ord.p2, vbx, vcx, vdx);
        p2y = pick(ord.p2, vby, vcy, vdy);
        p3x = pick(ord.p3, vbx, vcx, vdx);
        p3y = pick(ord.p3, vby, vcy, vdy);
        p4x = pick(ord.p4, vbx, vcx, vdx);
        p4y = pick(ord.p4, vby, vcy, vdy);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            v2x_reg <= p2x;
            v2y_reg <= p2y;
            v4x_reg <= p4x;
            v4y_reg <= p4y;
            ux_reg  <= U'(p3x) - U'(p2x);
            uy_reg  <= U'(p3y) - U'(p2y);
            wx_reg  <= U'(p4x) - U'(p3x);
            wy_reg  <= U'(p4y) - U'(p3y);
        end
    end

    assign v2x = v2x_reg;
    assign v2y = v2y_reg;
    assign v4x = v4x_reg;
    assign v4y = v4y_reg;
    assign ux  = ux_reg;
    assign uy  = uy_reg;
    assign wx  = wx_reg;
    assign wy  = wy_reg;

endmodule
`default_nettype wire

FILE: src/qc_measure.sv
// Stages 4 and 5: squared side lengths and right-angle tests.
`default_nettype none
module qc_measure #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic [1:0]                     adv,
    input  wire logic signed [COORD_WIDTH:0]    v2x,
    input  wire logic signed [COORD_WIDTH:0]    v2y,
    input  wire logic signed [COORD_WIDTH:0]    v4x,
    input  wire logic signed [COORD_WIDTH:0]    v4y,
    input  wire logic signed [COORD_WIDTH+1:0]  ux,
    input  wire logic signed [COORD_WIDTH+1:0]  uy,
    input  wire logic signed [COORD_WIDTH+1:0]  wx,
    input  wire logic signed [COORD_WIDTH+1:0]  wy,
    output logic signed [2*COORD_WIDTH+4:0]     s12,
    output logic signed [2*COORD_WIDTH+4:0]     s23,
    output logic signed [2*COORD_WIDTH+4:0]     s34,
    output logic signed [2*COORD_WIDTH+4:0]     s41,
    output logic                                right_angles
);
    import qc_pkg::*;

    localparam int PW = 2 * (COORD_WIDTH + 2);
    localparam int SW = PW + 1;

    // Stage 4: product terms
    logic signed [PW-1:0] a12x_reg, a12y_reg, a23x_reg, a23y_reg;
    logic signed [PW-1:0] a34x_reg, a34y_reg, a41x_reg, a41y_reg;
    logic signed [PW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, d3x_reg, d3y_reg;
    // Stage 5: sums
    logic signed [SW-1:0] s12_reg, s23_reg, s34_reg, s41_reg;
    logic                 rt_reg;

    logic signed [SW-1:0] dot1, dot2, dot3;

    // Corner one: (P2-P1).(P4-P1); corner three: (P3-P2).(P4-P3) up to sign;
    // corner two: (P3-P2).(P1-P2) up to sign. Only zero tests matter.
    assign dot1 = SW'(d1x_reg) + SW'(d1y_reg);
    assign dot2 = SW'(d2x_reg) + SW'(d2y_reg);
    assign dot3 = SW'(d3x_reg) + SW'(d3y_reg);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a12x_reg <= v2x * v2x;
            a12y_reg <= v2y * v2y;
            a23x_reg <= ux * ux;
            a23y_reg <= uy * uy;
            a34x_reg <= wx * wx;
            a34y_reg <= wy * wy;
            a41x_reg <= v4x * v4x;
            a41y_reg <= v4y * v4y;
            d1x_reg  <= v2x * v4x;
            d1y_reg  <= v2y * v4y;
            d2x_reg  <= ux * wx;
            d2y_reg  <= uy * wy;
            d3x_reg  <= ux * v2x;
            d3y_reg  <= uy * v2y;
        end
        if (adv[1]) begin
            s12_reg <= SW'(a12x_reg) + SW'(a12y_reg);
            s23_reg <= SW'(a23x_reg) + SW'(a23y_reg);
            s34_reg <= SW'(a34x_reg) + SW'(a34y_reg);
            s41_reg <= SW'(a41x_reg) + SW'(a41y_reg);
            rt_reg  <= (dot1 == '0) && (dot2 == '0) && (dot3 == '0);
        end
    end

    assign s12          = s12_reg;
    assign s23          = s23_reg;
    assign s34          = s34_reg;
    assign s41          = s41_reg;
    assign right_angles = rt_reg;

endmodule
`default_nettype wire

FILE: src/qc_decide.sv
// Stage 6: side-length comparisons and the output class register.
`default_nettype none
module qc_decide #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           adv,
    input  wire logic                           vld_in,
    input  wire logic signed [2*COORD_WIDTH+4:0] s12,
    input  wire logic signed [2*COORD_WIDTH+4:0] s23,
    input  wire logic signed [2*COORD_WIDTH+4:0] s34,
    input  wire logic signed [2*COORD_WIDTH+4:0] s41,
    input  wire logic                           right_angles,
    output qc_pkg::shape_class_t                shape_class
);
    import qc_pkg::*;

    shape_class_t cls_reg, cls_next;
    logic         all_equal, opposite_equal;

    always_comb begin
        all_equal      = (s12 == s23) && (s34 == s41) && (s12 == s41);
        opposite_equal = (s12 == s34) && (s23 == s41) && (s12 != s41);
        if (right_angles) begin
            if (all_equal) begin
                cls_next = SHAPE_SQUARE;
            end else if (opposite_equal) begin
                cls_next = SHAPE_RECTANGLE;
            end else begin
                cls_next = SHAPE_NOLABEL;
            end
        end else if (all_equal) begin
            cls_next = SHAPE_RHOMBUS;
        end else begin
            cls_next = SHAPE_OTHER;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cls_reg <= cls_next;
        end
    end

    assign shape_class = cls_reg;

    // A loaded class agrees with the right-angle test it came from
    a_class_matches_angles: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vld_in) |=>
            ((cls_reg == SHAPE_RHOMBUS || cls_reg == SHAPE_OTHER) == !$past(right_angles)))
        else $error("class does not match right-angle test");

endmodule
`default_nettype wire

FILE: src/quadrilateral_classifier.sv
// Top level of the quadrilateral classifier: handshake, valid chain and stage wiring.
//
// Usage:
//   Input channel s_*: four points A..D as signed COORD_WIDTH-bit coordinates,
//   taken when s_valid and s_ready are both high at a rising edge of aclk.
//   Result channel m_*: m_shape_class, 0 square, 1 rectangle, 2 rhombus,
//   3 other, 4 right angles at all tested corners but no label (degenerate).
//   Path: an accepted item passes through seven register stages before its
//   result is shown on m_valid (offsets, cross terms, cross signs, ordering,
//   length and dot terms, sums, class register).
//   Throughput: one item per cycle; every stage is one register deep and all
//   items are independent, so a new item enters every cycle while m_ready
//   stays high.
//   Stall: when m_ready is low the output register holds its item; each stage
//   advances only into an empty or advancing successor, so bubbles close up and
//   s_ready drops only when all seven stages are full.
//   Reset: aresetn low at a clock edge clears every valid bit; no item is in
//   flight afterwards. Datapath registers carry no reset.
`default_nettype none
module quadrilateral_classifier #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [COORD_WIDTH-1:0] s_ax,
    input  wire logic signed [COORD_WIDTH-1:0] s_ay,
    input  wire logic signed [COORD_WIDTH-1:0] s_bx,
    input  wire logic signed [COORD_WIDTH-1:0] s_by,
    input  wire logic signed [COORD_WIDTH-1:0] s_cx,
    input  wire logic signed [COORD_WIDTH-1:0] s_cy,
    input  wire logic signed [COORD_WIDTH-1:0] s_dx,
    input  wire logic signed [COORD_WIDTH-1:0] s_dy,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [2:0]                         m_shape_class
);
    import qc_pkg::*;

    // Valid bit of each stage and the advance enable of each stage
    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] adv;

    logic signed [COORD_WIDTH:0]     vbx, vby, vcx, vcy, vdx, vdy;
    cross_sign_t                     sgn_bc, sgn_bd, sgn_cd;
    logic signed [COORD_WIDTH:0]     v2x, v2y, v4x, v4y;
    logic signed [COORD_WIDTH+1:0]   ux, uy, wx, wy;
    logic signed [2*COORD_WIDTH+4:0] s12, s23, s34, s41;
    logic                            right_angles;
    shape_class_t                    shape_class;

    // A stage advances when it is empty or its successor advances
    always_comb begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready       = adv[0];
    assign m_valid       = vld_reg[NUM_STAGES-1];
    assign m_shape_class = shape_class;

    qc_cross #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cross (
        .aclk   (aclk),
        .adv    (adv[2:0]),
        .ax     (s_ax),
        .ay     (s_ay),
        .bx     (s_bx),
        .by     (s_by),
        .cx     (s_cx),
        .cy     (s_cy),
        .dx     (s_dx),
        .dy     (s_dy),
        .vbx    (vbx),
        .vby    (vby),
        .vcx    (vcx),
        .vcy    (vcy),
        .vdx    (vdx),
        .vdy    (vdy),
        .sgn_bc (sgn_bc),
        .sgn_bd (sgn_bd),
        .sgn_cd (sgn_cd)
    );

    qc_order #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_order (
        .aclk   (aclk),
        .adv    (adv[3]),
        .vbx    (vbx),
        .vby    (vby),
        .vcx    (vcx),
        .vcy    (vcy),
        .vdx    (vdx),
        .vdy    (vdy),
        .sgn_bc (sgn_bc),
        .sgn_bd (sgn_bd),
        .sgn_cd (sgn_cd),
        .v2x    (v2x),
        .v2y    (v2y),
        .v4x    (v4x),
        .v4y    (v4y),
        .ux     (ux),
        .uy     (uy),
        .wx     (wx),
        .wy     (wy)
    );

    qc_measure #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_measure (
        .aclk         (aclk),
        .adv          (adv[5:4]),
        .v2x          (v2x),
        .v2y          (v2y),
        .v4x          (v4x),
        .v4y          (v4y),
        .ux           (ux),
        .uy           (uy),
        .wx           (wx),
        .wy           (wy),
        .s12          (s12),
        .s23          (s23),
        .s34          (s34),
        .s41          (s41),
        .right_angles (right_angles)
    );

    qc_decide #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_decide (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv[6]),
        .vld_in       (vld_reg[5]),
        .s12          (s12),
        .s23          (s23),
        .s34          (s34),
        .s41          (s41),
        .right_angles (right_angles),
        .shape_class  (shape_class)
    );

    // Input is refused only when every stage is full and the output stalls
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> ((&vld_reg) && !m_ready))
        else $error("input refused with room in the pipeline");

    // An accepted item occupies the first stage on the next cycle
    a_accept_fills_stage0: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted item lost at pipeline entry");

    // No result is offered right after reset
    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (vld_reg == '0))
        else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire
